// ===== rtl/core/pcic_pkg.sv =====
`default_nettype none

package pcic_pkg;

    // widest cell index the line may need (NY up to 4096)
    localparam int CELL_W    = 12;
    // division datapath: 42-bit numerator magnitude, 25-bit positive divisor
    localparam int NUM_W     = 42;
    localparam int DEN_W     = 25;
    localparam int QUO_W     = NUM_W + 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    typedef enum logic [1:0] {
        ACT_DEPOSIT    = 2'd0,
        ACT_READ       = 2'd1,
        ACT_READ_CLEAR = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_REJECT,
        CMD_READ,
        CMD_DEPOSIT
    } cmd_kind_t;

    // one classified request handed from front to back
    typedef struct packed {
        cmd_kind_t          kind;
        logic               clear;
        logic [CELL_W-1:0]  j1;
        logic [CELL_W-1:0]  j2;
        logic signed [17:0] w1;
        logic signed [17:0] w2;
        logic signed [23:0] px;
        logic [23:0]        gam;
        logic [DEN_W-1:0]   den;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_EVAL,
        F_FRAC,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_RDATA,
        B_MUL,
        B_DIVC_GO,
        B_DIVC_WAIT,
        B_DIVD_GO,
        B_DIVD_WAIT,
        B_ACC,
        B_OUT
    } back_state_t;

    // saturating add of a grid cell and a contribution; msb is the clamp flag
    function automatic logic [32:0] sat_add(input logic signed [31:0] a,
                                            input logic signed [QUO_W-1:0] b);
        logic signed [QUO_W:0] s;
        logic [32:0]           r;
        s = {{(QUO_W-31){a[31]}}, a} + {b[QUO_W-1], b};
        if (s > $signed({{(QUO_W-31){1'b0}}, 32'h7fff_ffff})) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (s < $signed({{(QUO_W-31){1'b1}}, 32'h8000_0000})) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, s[31:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcic_div.sv =====
`default_nettype none

module pcic_div
    import pcic_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // restoring step: one quotient bit per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pcic_queue.sv =====
`default_nettype none

module pcic_queue
    import pcic_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'(QUEUE_DEPTH);
    assign head  = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcic_front.sv =====
`default_nettype none

module pcic_front
    import pcic_pkg::*;
#(
    parameter int NY = 512
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [23:0]        s_position,
    input  wire logic signed [17:0] s_weight,
    input  wire logic signed [23:0] s_momentum_x,
    input  wire logic [23:0]        s_lorentz_factor,
    input  wire logic [8:0]         s_cell_req,
    input  wire logic [23:0]        inv_cell_size,
    input  wire logic               clear_busy,
    output logic                    q_push,
    output cmd_t                    q_data,
    input  wire logic               q_full
);

    localparam int IW = $clog2(NY);
    localparam logic [IW:0] NY_V = (IW + 1)'(NY);
    // scaled reciprocal of NY; the quotient estimate is low by at most one
    localparam logic [27:0] RECIP = 28'((2 ** 28) / NY);

    front_state_t       state_reg, state_next;
    cmd_t               cmd_reg;
    logic [1:0]         act_reg;
    logic [23:0]        pos_reg;
    logic signed [17:0] w_reg;
    logic [8:0]         cell_reg;
    logic [47:0]        prod_reg;
    logic [15:0]        qe_reg;

    logic               accept;
    logic signed [25:0] d;
    logic               reject;
    logic               in_range;
    logic signed [34:0] wf;
    logic signed [18:0] w2_full;
    logic signed [18:0] w1_full;
    logic [43:0]        qe_full;
    logic [31:0]        qn;
    logic [16:0]        rem_full;
    logic [IW-1:0]      mod_next;
    logic [IW-1:0]      j2_next;

    // datapath helpers
    always_comb begin
        d         = $signed({2'b00, cmd_reg.gam}) - {{2{cmd_reg.px[23]}}, cmd_reg.px};
        reject    = d[25] || (d == 26'sd0);
        in_range  = 32'(cell_reg) < 32'(NY);
        wf        = w_reg * $signed({1'b0, prod_reg[31:16]});
        w2_full   = wf[34:16];
        w1_full   = {w_reg[17], w_reg} - w2_full;
        // integer cell mod NY: reciprocal estimate, then one correction
        qe_full   = 44'(prod_reg[47:32]) * 44'(RECIP);
        qn        = 32'(qe_reg) * 32'(NY);
        rem_full  = {1'b0, prod_reg[47:32]} - qn[16:0];
        mod_next  = (rem_full >= 17'(NY)) ? IW'(rem_full - 17'(NY)) : IW'(rem_full);
        j2_next   = ({1'b0, mod_next} == NY_V - 1'b1) ? '0 : IW'(mod_next + 1'b1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_EVAL;
            end
            F_EVAL: begin
                if (act_reg == ACT_DEPOSIT && !reject) state_next = F_FRAC;
                else state_next = F_PUSH;
            end
            F_FRAC: state_next = F_MOD;
            F_MOD:  state_next = F_PUSH;
            F_PUSH: begin
                if (!q_full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == F_IDLE) && !clear_busy;
        accept  = s_valid && s_ready;
        q_push  = (state_reg == F_PUSH) && !q_full;
        q_data  = cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request fields and classification
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    act_reg     <= s_action;
                    pos_reg     <= s_position;
                    w_reg       <= s_weight;
                    cell_reg    <= s_cell_req;
                    cmd_reg.px  <= s_momentum_x;
                    cmd_reg.gam <= s_lorentz_factor;
                end
            end
            F_EVAL: begin
                cmd_reg.clear <= act_reg == ACT_READ_CLEAR;
                cmd_reg.j1    <= CELL_W'(cell_reg);
                cmd_reg.den   <= d[DEN_W-1:0];
                prod_reg      <= 48'(pos_reg) * 48'(inv_cell_size);
                case (act_reg)
                    ACT_DEPOSIT:
                        cmd_reg.kind <= reject ? CMD_REJECT : CMD_DEPOSIT;
                    ACT_READ, ACT_READ_CLEAR:
                        cmd_reg.kind <= in_range ? CMD_READ : CMD_NOP;
                    default: cmd_reg.kind <= CMD_NOP;
                endcase
            end
            F_FRAC: begin
                cmd_reg.w2 <= w2_full[17:0];
                cmd_reg.w1 <= w1_full[17:0];
                qe_reg     <= qe_full[43:28];
            end
            F_MOD: begin
                cmd_reg.j1 <= CELL_W'(mod_next);
                cmd_reg.j2 <= CELL_W'(j2_next);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/pcic_back.sv =====
`default_nettype none

module pcic_back
    import pcic_pkg::*;
#(
    parameter int NY = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        head,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic             clear_busy,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_source_sum,
    output logic [31:0]      m_current_sum,
    output logic [31:0]      m_density_sum,
    output logic [1:0]       m_status
);

    localparam int IW = $clog2(NY);

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic        sel_reg;
    logic        sat_reg;
    logic [IW-1:0] clr_addr_reg;

    logic signed [31:0] src_mem [NY];
    logic signed [31:0] cur_mem [NY];
    logic signed [31:0] den_mem [NY];
    logic signed [31:0] rd_src_reg, rd_cur_reg, rd_den_reg;

    logic signed [41:0]      prod_c_reg;
    logic signed [42:0]      prod_d_reg;
    logic signed [QUO_W-1:0] q_c_reg, q_d_reg;
    logic                    neg_reg;

    logic [31:0] res_src_reg, res_cur_reg, res_den_reg;
    logic [1:0]  res_status_reg;
    logic        m_valid_reg;
    logic [31:0] m_src_reg, m_cur_reg, m_den_reg;
    logic [1:0]  m_status_reg;

    logic               rd_en;
    logic [IW-1:0]      raddr;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [31:0]        wd_src, wd_cur, wd_den;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic               out_load;
    logic signed [17:0] wk;
    logic [IW-1:0]      jk;
    logic signed [42:0] neg_pd;
    logic signed [41:0] neg_pc;
    logic signed [QUO_W-1:0] q_signed;
    logic [32:0]        sum_src, sum_cur, sum_den;
    logic               sat_now;

    pcic_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (cmd_reg.den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // per-cell operands and saturating sums
    always_comb begin
        wk       = sel_reg ? cmd_reg.w2 : cmd_reg.w1;
        jk       = sel_reg ? cmd_reg.j2[IW-1:0] : cmd_reg.j1[IW-1:0];
        neg_pc   = -prod_c_reg;
        neg_pd   = -prod_d_reg;
        q_signed = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        sum_src  = sat_add(rd_src_reg, -{{(QUO_W-18){wk[17]}}, wk});
        sum_cur  = sat_add(rd_cur_reg, q_c_reg);
        sum_den  = sat_add(rd_den_reg, q_d_reg);
        sat_now  = sum_src[32] | sum_cur[32] | sum_den[32];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (32'(clr_addr_reg) == 32'(NY - 1)) state_next = B_IDLE;
            end
            B_IDLE: begin
                if (!q_empty) begin
                    case (head.kind)
                        CMD_READ:    state_next = B_READ;
                        CMD_DEPOSIT: state_next = B_MUL;
                        default:     state_next = B_OUT;
                    endcase
                end
            end
            B_READ:      state_next = B_RDATA;
            B_RDATA:     state_next = B_OUT;
            B_MUL:       state_next = B_DIVC_GO;
            B_DIVC_GO:   state_next = B_DIVC_WAIT;
            B_DIVC_WAIT: begin
                if (div_done) state_next = B_DIVD_GO;
            end
            B_DIVD_GO:   state_next = B_DIVD_WAIT;
            B_DIVD_WAIT: begin
                if (div_done) state_next = B_ACC;
            end
            B_ACC:       state_next = sel_reg ? B_OUT : B_MUL;
            B_OUT: begin
                if (out_load) state_next = B_IDLE;
            end
            default:     state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop      = (state_reg == B_IDLE) && !q_empty;
        clear_busy = state_reg == B_CLEAR;
        rd_en      = 1'b0;
        raddr      = cmd_reg.j1[IW-1:0];
        we         = 1'b0;
        waddr      = cmd_reg.j1[IW-1:0];
        wd_src     = '0;
        wd_cur     = '0;
        wd_den     = '0;
        div_start  = 1'b0;
        div_num    = '0;
        out_load   = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = clr_addr_reg;
            end
            B_READ: rd_en = 1'b1;
            B_RDATA: we = cmd_reg.clear;
            B_MUL: begin
                rd_en = 1'b1;
                raddr = jk;
            end
            B_DIVC_GO: begin
                div_start = 1'b1;
                div_num   = prod_c_reg[41] ? NUM_W'(neg_pc) : NUM_W'(prod_c_reg);
            end
            B_DIVD_GO: begin
                div_start = 1'b1;
                div_num   = prod_d_reg[42] ? neg_pd[NUM_W-1:0] : prod_d_reg[NUM_W-1:0];
            end
            B_ACC: begin
                we     = 1'b1;
                waddr  = jk;
                wd_src = sum_src[31:0];
                wd_cur = sum_cur[31:0];
                wd_den = sum_den[31:0];
            end
            B_OUT: out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    // grid memories
    always_ff @(posedge aclk) begin
        if (we) begin
            src_mem[waddr] <= wd_src;
            cur_mem[waddr] <= wd_cur;
            den_mem[waddr] <= wd_den;
        end
        if (rd_en) begin
            rd_src_reg <= src_mem[raddr];
            rd_cur_reg <= cur_mem[raddr];
            rd_den_reg <= den_mem[raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    cmd_reg        <= head;
                    sel_reg        <= 1'b0;
                    sat_reg        <= 1'b0;
                    res_src_reg    <= '0;
                    res_cur_reg    <= '0;
                    res_den_reg    <= '0;
                    res_status_reg <= (head.kind == CMD_REJECT) ? ST_REJECT : ST_OK;
                end
            end
            B_RDATA: begin
                res_src_reg <= rd_src_reg;
                res_cur_reg <= rd_cur_reg;
                res_den_reg <= rd_den_reg;
            end
            B_MUL: begin
                prod_c_reg <= wk * cmd_reg.px;
                prod_d_reg <= wk * $signed({1'b0, cmd_reg.gam});
            end
            B_DIVC_GO: neg_reg <= prod_c_reg[41];
            B_DIVC_WAIT: begin
                if (div_done) q_c_reg <= q_signed;
            end
            B_DIVD_GO: neg_reg <= prod_d_reg[42];
            B_DIVD_WAIT: begin
                if (div_done) q_d_reg <= q_signed;
            end
            B_ACC: begin
                sel_reg <= 1'b1;
                sat_reg <= sat_reg | sat_now;
                if (sel_reg) begin
                    res_status_reg <= (sat_reg | sat_now) ? ST_SAT : ST_OK;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_src_reg    <= res_src_reg;
            m_cur_reg    <= res_cur_reg;
            m_den_reg    <= res_den_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_source_sum  = m_src_reg;
    assign m_current_sum = m_cur_reg;
    assign m_density_sum = m_den_reg;
    assign m_status      = m_status_reg;

`ifndef SYNTHESIS
    // sweep finishes on the last cell before leaving
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_CLEAR && state_next != B_CLEAR)
            |-> 32'(clr_addr_reg) == 32'(NY - 1))
        else $error("clear sweep ended early");

    // a held result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while stalled");

    // divider is only started from its go states, one at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> !div_start && !div_done)
        else $error("divider restarted");

    // grid writes stay on the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> 32'(waddr) < 32'(NY))
        else $error("grid write out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/periodic_cloud_in_cell_deposit.sv =====
// Channel  | handshake           | payload
// s_       | s_valid / s_ready   | action, position, weight, momentum_x, lorentz_factor, cell_req
// m_       | m_valid / m_ready   | source_sum, current_sum, density_sum, status
// cfg_     | cfg_valid/cfg_ready | inv_cell_size (24 bit)
//
// A deposit is dominated by the 42-step restoring divider, run four times per
// particle (two divisions for each of the two cells); reads skip the divider.
// After reset a sweep over all NY cells zeroes the grids; s_ready stays low meanwhile.
// Front and back are parted by a two-entry queue; results wait in an output register so
// the back can start the next request while m_ready is low, then waits for the held result to be taken.
`default_nettype none

module periodic_cloud_in_cell_deposit
    import pcic_pkg::*;
#(
    parameter int NY = 512
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_action,
    input  wire logic [23:0]        s_position,
    input  wire logic signed [17:0] s_weight,
    input  wire logic signed [23:0] s_momentum_x,
    input  wire logic [23:0]        s_lorentz_factor,
    input  wire logic [8:0]         s_cell_req,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_source_sum,
    output logic signed [31:0]      m_current_sum,
    output logic signed [31:0]      m_density_sum,
    output logic [1:0]              m_status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [23:0]        cfg_data
);

    logic [23:0] inv_cell_size_reg;
    logic        clear_busy;
    logic        q_push, q_pop, q_empty, q_full;
    cmd_t        q_in, q_head;

    // config register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_cell_size_reg <= 24'd1310720;
        end else if (cfg_valid) begin
            inv_cell_size_reg <= cfg_data;
        end
    end

    pcic_front #(.NY(NY)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_position       (s_position),
        .s_weight         (s_weight),
        .s_momentum_x     (s_momentum_x),
        .s_lorentz_factor (s_lorentz_factor),
        .s_cell_req       (s_cell_req),
        .inv_cell_size    (inv_cell_size_reg),
        .clear_busy       (clear_busy),
        .q_push           (q_push),
        .q_data           (q_in),
        .q_full           (q_full)
    );

    pcic_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    pcic_back #(.NY(NY)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .clear_busy    (clear_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_source_sum  (m_source_sum),
        .m_current_sum (m_current_sum),
        .m_density_sum (m_density_sum),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire
